>>> src/ktr_pkg.sv
// ----------------------------------------------------------------------------
// ktr_pkg: shared types and codes for the keyed ranking table
// Command and status codes, field widths, control structs and the result item.
// ----------------------------------------------------------------------------
package ktr_pkg;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 16;
    localparam int SCORE_W  = 32;
    localparam int STATUS_W = 4;
    localparam int POS_W    = 3;
    localparam int CNT_W    = 3;

    localparam logic [CMD_W-1:0] CMD_UPSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_ADDED     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_EVICT     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_RAISED    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NOTIMP    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 4'd8;
    localparam logic [STATUS_W-1:0] ST_LISTENT   = 4'd9;
    localparam logic [STATUS_W-1:0] ST_LISTEMPTY = 4'd10;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, run cell compares
        logic exec;       // apply command to the table
        logic list_step;  // present one list entry, rotate table
        logic emit;       // result goes to the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cmd_known;
        logic cmd_list;
        logic cnt_zero;
        logic list_last;
    } ctrl_stat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         position;
        logic [ID_W-1:0]          entry_id;
        logic signed [SCORE_W-1:0] entry_score;
        logic [CNT_W-1:0]         count;
        logic                     last;
    } result_t;

endpackage

>>> src/ktr_ctrl.sv
// ----------------------------------------------------------------------------
// ktr_ctrl: command sequencer
// Accepts one request, runs the execute cycle, then steps list runs.
// ----------------------------------------------------------------------------
module ktr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_free,
    input  ktr_pkg::ctrl_stat_t stat,
    output ktr_pkg::ctrl_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.cmd_known)
                begin
                    state_next = S_IDLE;  // no result, no table change
                end
                else if (stat.cmd_list && !stat.cnt_zero)
                begin
                    state_next = S_LIST;
                end
                else if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    cmd.list_step = 1'b1;
                    cmd.emit      = 1'b1;
                    if (stat.list_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/ktr_dp.sv
// ----------------------------------------------------------------------------
// ktr_dp: ranking table datapath
// Row of cells with per-cell compare, shift-insert, shift-remove and rotate.
// ----------------------------------------------------------------------------
module ktr_dp
#(
    parameter int TABLE_SIZE = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ktr_pkg::ctrl_cmd_t                  cmd,
    input  logic [ktr_pkg::CMD_W-1:0]           in_command,
    input  logic [ktr_pkg::ID_W-1:0]            in_player_id,
    input  logic signed [ktr_pkg::SCORE_W-1:0]  in_score,
    output ktr_pkg::ctrl_stat_t                 stat,
    output ktr_pkg::result_t                    res
);

    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam logic [CW-1:0] FULL = CW'(TABLE_SIZE);

    logic [ktr_pkg::ID_W-1:0]           id_reg   [TABLE_SIZE];
    logic [ktr_pkg::ID_W-1:0]           id_next  [TABLE_SIZE];
    logic signed [ktr_pkg::SCORE_W-1:0] sc_reg   [TABLE_SIZE];
    logic signed [ktr_pkg::SCORE_W-1:0] sc_next  [TABLE_SIZE];
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      lidx_reg, lidx_next;
    logic [ktr_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic [ktr_pkg::ID_W-1:0]           pid_reg, pid_next;
    logic signed [ktr_pkg::SCORE_W-1:0] scr_reg, scr_next;
    logic [TABLE_SIZE-1:0]              match_reg, match_next;
    logic [TABLE_SIZE-1:0]              ge_reg, ge_next;

    logic                               hit, notimp, all_ge, cnt_full;
    logic [TABLE_SIZE-1:0]              boundary;
    logic [IW-1:0]                      slot_idx, p_idx;
    logic signed [ktr_pkg::SCORE_W-1:0] sel_sc;
    logic [CW-1:0]                      count_m1;

    // request capture and cell compares
    always_comb
    begin
        cmd_next   = cmd_reg;
        pid_next   = pid_reg;
        scr_next   = scr_reg;
        match_next = match_reg;
        ge_next    = ge_reg;
        if (cmd.load)
        begin
            cmd_next = in_command;
            pid_next = in_player_id;
            scr_next = in_score;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                match_next[i] = (CW'(i) < count_reg) && (id_reg[i] == in_player_id);
                ge_next[i]    = (CW'(i) < count_reg) && (sc_reg[i] >= in_score);
            end
        end
    end

    // decode of compare vectors; ge is a prefix since the table is sorted
    always_comb
    begin
        hit      = |match_reg;
        notimp   = |(match_reg & ge_reg);
        all_ge   = &ge_reg;
        cnt_full = (count_reg == FULL);
        count_m1 = count_reg - CW'(1);
        slot_idx = '0;
        p_idx    = '0;
        sel_sc   = '0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (i == 0)
            begin
                boundary[i] = !ge_reg[i];
            end
            else
            begin
                boundary[i] = !ge_reg[i] && ge_reg[i-1];
            end
            if (match_reg[i])
            begin
                slot_idx = slot_idx | IW'(i);
                sel_sc   = sel_sc | sc_reg[i];
            end
            if (boundary[i])
            begin
                p_idx = p_idx | IW'(i);
            end
        end
    end

    // table update
    always_comb
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            id_next[i] = id_reg[i];
            sc_next[i] = sc_reg[i];
        end
        count_next = count_reg;
        lidx_next  = lidx_reg;

        if (cmd.load)
        begin
            lidx_next = '0;
        end

        if (cmd.exec)
        begin
            unique case (cmd_reg)
                ktr_pkg::CMD_UPSERT:
                begin
                    if (hit && !notimp)
                    begin
                        // raise: new rank is at or above the old slot
                        for (int i = 1; i < TABLE_SIZE; i++)
                        begin
                            if (!ge_reg[i] && (IW'(i) <= slot_idx))
                            begin
                                id_next[i] = id_reg[i-1];
                                sc_next[i] = sc_reg[i-1];
                            end
                        end
                        for (int i = 0; i < TABLE_SIZE; i++)
                        begin
                            if (boundary[i])
                            begin
                                id_next[i] = pid_reg;
                                sc_next[i] = scr_reg;
                            end
                        end
                    end
                    else if (!hit && !all_ge)
                    begin
                        // insert, tail entry falls off when full
                        for (int i = 1; i < TABLE_SIZE; i++)
                        begin
                            if (!ge_reg[i])
                            begin
                                id_next[i] = id_reg[i-1];
                                sc_next[i] = sc_reg[i-1];
                            end
                        end
                        for (int i = 0; i < TABLE_SIZE; i++)
                        begin
                            if (boundary[i])
                            begin
                                id_next[i] = pid_reg;
                                sc_next[i] = scr_reg;
                            end
                        end
                        if (!cnt_full)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                ktr_pkg::CMD_REMOVE:
                begin
                    if (hit)
                    begin
                        for (int i = 0; i < TABLE_SIZE - 1; i++)
                        begin
                            if (IW'(i) >= slot_idx)
                            begin
                                id_next[i] = id_reg[i+1];
                                sc_next[i] = sc_reg[i+1];
                            end
                        end
                        count_next = count_m1;
                    end
                end
                ktr_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.list_step)
        begin
            // rotate live entries by one; after a full run the order is back
            for (int i = 0; i < TABLE_SIZE - 1; i++)
            begin
                id_next[i] = id_reg[i+1];
                sc_next[i] = sc_reg[i+1];
            end
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                if (CW'(i) == count_m1)
                begin
                    id_next[i] = id_reg[0];
                    sc_next[i] = sc_reg[0];
                end
            end
            lidx_next = lidx_reg + CW'(1);
        end
    end

    // result item
    always_comb
    begin
        res             = '0;
        res.last        = 1'b1;
        res.count       = ktr_pkg::CNT_W'(count_next);
        res.entry_id    = pid_reg;
        unique case (cmd_reg)
            ktr_pkg::CMD_UPSERT:
            begin
                if (hit && notimp)
                begin
                    res.status      = ktr_pkg::ST_NOTIMP;
                    res.position    = ktr_pkg::POS_W'(slot_idx);
                    res.entry_score = sel_sc;
                end
                else if (hit)
                begin
                    res.status      = ktr_pkg::ST_RAISED;
                    res.position    = ktr_pkg::POS_W'(p_idx);
                    res.entry_score = scr_reg;
                end
                else if (all_ge)
                begin
                    res.status      = ktr_pkg::ST_DROPPED;
                    res.entry_score = scr_reg;
                end
                else if (cnt_full)
                begin
                    res.status      = ktr_pkg::ST_EVICT;
                    res.position    = ktr_pkg::POS_W'(p_idx);
                    res.entry_id    = id_reg[TABLE_SIZE-1];
                    res.entry_score = sc_reg[TABLE_SIZE-1];
                end
                else
                begin
                    res.status      = ktr_pkg::ST_ADDED;
                    res.position    = ktr_pkg::POS_W'(p_idx);
                    res.entry_score = scr_reg;
                end
            end
            ktr_pkg::CMD_REMOVE, ktr_pkg::CMD_FIND:
            begin
                if (hit)
                begin
                    res.status      = (cmd_reg == ktr_pkg::CMD_REMOVE) ?
                                      ktr_pkg::ST_REMOVED : ktr_pkg::ST_FOUND;
                    res.position    = ktr_pkg::POS_W'(slot_idx);
                    res.entry_score = sel_sc;
                end
                else
                begin
                    res.status = ktr_pkg::ST_NOTFOUND;
                end
            end
            ktr_pkg::CMD_CLEAR:
            begin
                res.status   = ktr_pkg::ST_CLEARED;
                res.entry_id = '0;
            end
            ktr_pkg::CMD_LIST:
            begin
                if (count_reg == '0)
                begin
                    res.status   = ktr_pkg::ST_LISTEMPTY;
                    res.entry_id = '0;
                end
                else
                begin
                    res.status      = ktr_pkg::ST_LISTENT;
                    res.position    = ktr_pkg::POS_W'(lidx_reg);
                    res.entry_id    = id_reg[0];
                    res.entry_score = sc_reg[0];
                    res.last        = (lidx_reg == count_m1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.cmd_known = (cmd_reg == ktr_pkg::CMD_UPSERT) || (cmd_reg == ktr_pkg::CMD_REMOVE) ||
                         (cmd_reg == ktr_pkg::CMD_CLEAR)  || (cmd_reg == ktr_pkg::CMD_FIND)   ||
                         (cmd_reg == ktr_pkg::CMD_LIST);
        stat.cmd_list  = (cmd_reg == ktr_pkg::CMD_LIST);
        stat.cnt_zero  = (count_reg == '0);
        stat.list_last = (lidx_reg == count_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            id_reg[i] <= id_next[i];
            sc_reg[i] <= sc_next[i];
        end
        lidx_reg  <= lidx_next;
        cmd_reg   <= cmd_next;
        pid_reg   <= pid_next;
        scr_reg   <= scr_next;
        match_reg <= match_next;
        ge_reg    <= ge_next;
    end

endmodule

>>> src/top_k_keyed_ranking_table_unit.sv
// ----------------------------------------------------------------------------
// top_k_keyed_ranking_table_unit: top-K table of (id, score) ranked by score
// Upsert, remove, clear, find and list over a sorted row of cells.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata: command, player_id, score
//  m_*       out        m_tvalid/m_tready  m_tdata: status..count, m_tlast: last
//
// Steps: a request is captured with all cell compares, then the execute step
// shifts the cells; a list request then presents one entry per cycle while the
// output is free, as the table rotates through cell 0.
// One request is in flight at a time; a new request is taken while the output
// register still holds the previous result.
// Reset clears the entry count and control; cell contents need no reset.
// A stalled m_tready holds the result and pauses execute and list stepping.
//
module top_k_keyed_ranking_table_unit
#(
    parameter int TABLE_SIZE = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // command[2:0], player_id[18:3], score[50:19], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // status[3:0], position[6:4], entry_id[22:7],
                                   // entry_score[54:23], count[57:55], zero pad
    output logic        m_tlast
);

    ktr_pkg::ctrl_cmd_t  cmd;
    ktr_pkg::ctrl_stat_t stat;
    ktr_pkg::result_t    res;
    ktr_pkg::result_t    res_reg;
    logic                m_valid_reg, m_valid_next;
    logic                out_free;

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    ktr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    ktr_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_command   (s_tdata[2:0]),
        .in_player_id (s_tdata[18:3]),
        .in_score     (s_tdata[50:19]),
        .stat         (stat),
        .res          (res)
    );

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (cmd.emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {6'b0, res_reg.count, res_reg.entry_score, res_reg.entry_id,
                       res_reg.position, res_reg.status};

`ifndef SYNTH
    // one request at a time: ready drops right after an accept
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // never overwrite a result that is still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_valid_reg || m_tready))
        else $error("result emitted into a full output register");

    // only list entries may come without last
    a_last_list: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> res_reg.status == ktr_pkg::ST_LISTENT)
        else $error("non-list result without last");
`endif

endmodule

>>> bench/tb_top_k_keyed_ranking_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_keyed_ranking_table_unit: self-checking bench for the top-K table
// Drives upsert/remove/clear/find/list requests over the s_* stream, keeps a
// shadow copy of the ranked table, and checks every m_* result field by field.
// ----------------------------------------------------------------------------
module tb_top_k_keyed_ranking_table_unit;

    localparam int TBL_K         = 5;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = TBL_K + 4;   // longest request is a full list
    localparam int HOLD_CYCLES   = 300;         // long output stall
    localparam int HOLD_BURST    = 12;          // requests offered during the stall
    localparam int END_WAIT      = 5000;
    localparam int ID_POOL       = 10;          // small id pool, twice K, for hits

    // codes the block has to ignore
    localparam logic [ktr_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [ktr_pkg::CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [ktr_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    // one row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [ktr_pkg::CMD_W-1:0]   cmd;
        logic [ktr_pkg::ID_W-1:0]    id;
        logic [ktr_pkg::SCORE_W-1:0] score;
        logic                        typed;
        ktr_pkg::result_t            want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;    // command[2:0], player_id[18:3], score[50:19], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // status[3:0], position[6:4], entry_id[22:7],
                             // entry_score[54:23], count[57:55], zero pad
    logic        m_tlast;

    // shadow of the ranked table, highest score first
    logic [ktr_pkg::ID_W-1:0]           shadow_ids    [TBL_K];
    logic signed [ktr_pkg::SCORE_W-1:0] shadow_scores [TBL_K];
    int                                 shadow_count;

    ktr_pkg::result_t ranking_results_due [$];   // results owed by the block, oldest first
    stim_row_t        directed_rows [$];

    // handshake between the sender and the receiver for the long stall
    logic long_hold_req;
    logic hold_active;
    logic quiet_tail;      // last part of the run: no idling on either side

    int mismatches;
    int n_requests;
    int n_ignored;
    int n_results;
    int n_list_runs;
    int n_evict;
    int n_raised;
    int n_dropped;

    top_k_keyed_ranking_table_unit #(
        .TABLE_SIZE (TBL_K)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------------

    function automatic ktr_pkg::result_t result_of(input logic [ktr_pkg::STATUS_W-1:0] st,
                                                   input int pos,
                                                   input logic [ktr_pkg::ID_W-1:0] id,
                                                   input logic [ktr_pkg::SCORE_W-1:0] sc,
                                                   input int cnt, input logic last);
        ktr_pkg::result_t r;
        r.status      = st;
        r.position    = pos[ktr_pkg::POS_W-1:0];
        r.entry_id    = id;
        r.entry_score = sc;
        r.count       = cnt[ktr_pkg::CNT_W-1:0];
        r.last        = last;
        return r;
    endfunction

    // count field always reflects the table after the request
    function automatic ktr_pkg::result_t shadow_result(
                                              input logic [ktr_pkg::STATUS_W-1:0] st,
                                              input int pos,
                                              input logic [ktr_pkg::ID_W-1:0] id,
                                              input logic [ktr_pkg::SCORE_W-1:0] sc,
                                              input logic last);
        return result_of(st, pos, id, sc, shadow_count, last);
    endfunction

    task automatic shadow_remove(input int p);
        int i;
        for (i = p; i + 1 < shadow_count; i++)
        begin
            shadow_ids[i]    = shadow_ids[i + 1];
            shadow_scores[i] = shadow_scores[i + 1];
        end
        if (shadow_count > 0)
            shadow_count--;
    endtask

    // Goes in after every entry with an equal or higher score. Returns TBL_K
    // when the entry falls off the end of a full table.
    function automatic int shadow_insert(input logic [ktr_pkg::ID_W-1:0] id,
                                         input logic signed [ktr_pkg::SCORE_W-1:0] sc,
                                         output logic evicted,
                                         output logic [ktr_pkg::ID_W-1:0] ev_id,
                                         output logic signed [ktr_pkg::SCORE_W-1:0] ev_sc);
        int p;
        int i;
        evicted = 1'b0;
        ev_id   = '0;
        ev_sc   = '0;
        p       = 0;
        while (p < shadow_count && shadow_scores[p] >= sc)
            p++;
        if (p >= TBL_K)
            return TBL_K;
        if (shadow_count >= TBL_K)
        begin
            evicted      = 1'b1;
            ev_id        = shadow_ids[TBL_K - 1];
            ev_sc        = shadow_scores[TBL_K - 1];
            shadow_count = TBL_K - 1;
        end
        for (i = shadow_count; i > p; i--)
        begin
            shadow_ids[i]    = shadow_ids[i - 1];
            shadow_scores[i] = shadow_scores[i - 1];
        end
        shadow_ids[p]    = id;
        shadow_scores[p] = sc;
        shadow_count++;
        return p;
    endfunction

    // Applies one accepted request to the shadow table and queues what the
    // block owes for it. A typed row queues its hand-written result instead.
    task automatic apply_ranking_request(input logic [ktr_pkg::CMD_W-1:0] cmd,
                                         input logic [ktr_pkg::ID_W-1:0] id,
                                         input logic signed [ktr_pkg::SCORE_W-1:0] sc,
                                         input logic typed, input ktr_pkg::result_t want);
        int                                 slot;
        int                                 p;
        int                                 i;
        logic                               ev;
        logic [ktr_pkg::ID_W-1:0]           ev_id;
        logic signed [ktr_pkg::SCORE_W-1:0] ev_sc;
        logic signed [ktr_pkg::SCORE_W-1:0] old_sc;
        ktr_pkg::result_t                   batch [$];

        slot = -1;
        for (i = 0; i < shadow_count; i++)
            if (slot < 0 && shadow_ids[i] == id)
                slot = i;

        case (cmd)
            ktr_pkg::CMD_UPSERT:
            begin
                if (slot >= 0)
                begin
                    old_sc = shadow_scores[slot];
                    if (sc <= old_sc)
                        batch.push_back(shadow_result(ktr_pkg::ST_NOTIMP, slot, id, old_sc,
                                                      1'b1));
                    else
                    begin
                        // take out, then insert by the usual rule; never evicts
                        shadow_remove(slot);
                        p = shadow_insert(id, sc, ev, ev_id, ev_sc);
                        batch.push_back(shadow_result(ktr_pkg::ST_RAISED, p, id, sc, 1'b1));
                    end
                end
                else
                begin
                    p = shadow_insert(id, sc, ev, ev_id, ev_sc);
                    if (p >= TBL_K)
                        batch.push_back(shadow_result(ktr_pkg::ST_DROPPED, 0, id, sc, 1'b1));
                    else if (ev)
                        batch.push_back(shadow_result(ktr_pkg::ST_EVICT, p, ev_id, ev_sc,
                                                      1'b1));
                    else
                        batch.push_back(shadow_result(ktr_pkg::ST_ADDED, p, id, sc, 1'b1));
                end
            end
            ktr_pkg::CMD_REMOVE:
            begin
                if (slot < 0)
                    batch.push_back(shadow_result(ktr_pkg::ST_NOTFOUND, 0, id, '0, 1'b1));
                else
                begin
                    old_sc = shadow_scores[slot];
                    shadow_remove(slot);
                    batch.push_back(shadow_result(ktr_pkg::ST_REMOVED, slot, id, old_sc,
                                                  1'b1));
                end
            end
            ktr_pkg::CMD_CLEAR:
            begin
                shadow_count = 0;
                batch.push_back(shadow_result(ktr_pkg::ST_CLEARED, 0, '0, '0, 1'b1));
            end
            ktr_pkg::CMD_FIND:
            begin
                if (slot < 0)
                    batch.push_back(shadow_result(ktr_pkg::ST_NOTFOUND, 0, id, '0, 1'b1));
                else
                    batch.push_back(shadow_result(ktr_pkg::ST_FOUND, slot, id,
                                                  shadow_scores[slot], 1'b1));
            end
            ktr_pkg::CMD_LIST:
            begin
                n_list_runs++;
                if (shadow_count == 0)
                    batch.push_back(shadow_result(ktr_pkg::ST_LISTEMPTY, 0, '0, '0, 1'b1));
                else
                    for (i = 0; i < shadow_count; i++)
                        batch.push_back(shadow_result(ktr_pkg::ST_LISTENT, i, shadow_ids[i],
                                                      shadow_scores[i],
                                                      (i + 1 == shadow_count)));
            end
            default:
                n_ignored++;
        endcase

        foreach (batch[j])
        begin
            case (batch[j].status)
                ktr_pkg::ST_EVICT:   n_evict++;
                ktr_pkg::ST_RAISED:  n_raised++;
                ktr_pkg::ST_DROPPED: n_dropped++;
                default:             ;
            endcase
        end

        if (typed)
            ranking_results_due.push_back(want);
        else
            foreach (batch[j])
                ranking_results_due.push_back(batch[j]);
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    task automatic sender_idle(input int n);
        @(negedge clk) s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // present one request at the falling edge, hold it until accepted
    task automatic send_request(input logic [ktr_pkg::CMD_W-1:0] cmd,
                                input logic [ktr_pkg::ID_W-1:0] id,
                                input logic [ktr_pkg::SCORE_W-1:0] sc, input logic typed,
                                input ktr_pkg::result_t want);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, sc, id, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_requests++;
        apply_ranking_request(cmd, id, sc, typed, want);
    endtask

    // pause requests until every owed result is back and the block is idle
    task automatic drain_results();
        sender_idle(1);
        while (ranking_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input logic [ktr_pkg::CMD_W-1:0] cmd,
                           input logic [ktr_pkg::ID_W-1:0] id,
                           input logic [ktr_pkg::SCORE_W-1:0] sc, input logic typed,
                           input ktr_pkg::result_t want);
        stim_row_t row;
        row.cmd   = cmd;
        row.id    = id;
        row.score = sc;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Directed sequence. Typed results: empty table, extremes, drop and clear.
    // Others come from the shadow table.
    task automatic build_directed();
        ktr_pkg::result_t none;
        none = '0;
        // empty table: list, find of id zero, remove of the top id
        add_row(ktr_pkg::CMD_LIST,   16'h0000, 32'h0, 1'b1,
                result_of(ktr_pkg::ST_LISTEMPTY, 0, 16'h0000, 32'h0, 0, 1'b1));
        add_row(ktr_pkg::CMD_FIND,   16'h0000, 32'h0, 1'b1,
                result_of(ktr_pkg::ST_NOTFOUND, 0, 16'h0000, 32'h0, 0, 1'b1));
        add_row(ktr_pkg::CMD_REMOVE, 16'hFFFF, 32'h0, 1'b1,
                result_of(ktr_pkg::ST_NOTFOUND, 0, 16'hFFFF, 32'h0, 0, 1'b1));
        // score extremes with id extremes
        add_row(ktr_pkg::CMD_UPSERT, 16'h0000, 32'h7FFF_FFFF, 1'b1,
                result_of(ktr_pkg::ST_ADDED, 0, 16'h0000, 32'h7FFF_FFFF, 1, 1'b1));
        add_row(ktr_pkg::CMD_UPSERT, 16'hFFFF, 32'h8000_0000, 1'b1,
                result_of(ktr_pkg::ST_ADDED, 1, 16'hFFFF, 32'h8000_0000, 2, 1'b1));
        // ties go after the equal entry
        add_row(ktr_pkg::CMD_UPSERT, 16'h0001, 32'h0000_0000, 1'b0, none);
        add_row(ktr_pkg::CMD_UPSERT, 16'h0002, 32'h0000_0000, 1'b0, none);
        add_row(ktr_pkg::CMD_UPSERT, 16'h0003, 32'h0000_0100, 1'b0, none);
        // full table: new entry equal to the last one falls off itself
        add_row(ktr_pkg::CMD_UPSERT, 16'h0004, 32'h8000_0000, 1'b1,
                result_of(ktr_pkg::ST_DROPPED, 0, 16'h0004, 32'h8000_0000, 5, 1'b1));
        // full table: new entry evicts the last one
        add_row(ktr_pkg::CMD_UPSERT, 16'h0005, 32'h0000_0200, 1'b0, none);
        // known id, equal then lower score: kept
        add_row(ktr_pkg::CMD_UPSERT, 16'h0001, 32'h0000_0000, 1'b0, none);
        add_row(ktr_pkg::CMD_UPSERT, 16'h0001, 32'hFFFF_FFFB, 1'b0, none);
        // known id raised to tie with the top
        add_row(ktr_pkg::CMD_UPSERT, 16'h0002, 32'h7FFF_FFFF, 1'b0, none);
        add_row(ktr_pkg::CMD_FIND,   16'h0003, 32'h0, 1'b0, none);
        add_row(ktr_pkg::CMD_LIST,   16'h0000, 32'h0, 1'b0, none);
        // unknown codes, no result
        add_row(CMD_RSVD5,  16'h0001, 32'h1234_5678, 1'b0, none);
        add_row(CMD_RSVD6,  16'hFFFF, 32'hFFFF_FFFF, 1'b0, none);
        add_row(CMD_RSVD7,  16'h0002, 32'h8000_0000, 1'b0, none);
        // remove the top, then a lower one
        add_row(ktr_pkg::CMD_REMOVE, 16'h0000, 32'h0, 1'b0, none);
        add_row(ktr_pkg::CMD_REMOVE, 16'h0001, 32'h0, 1'b0, none);
        add_row(ktr_pkg::CMD_LIST,   16'h0000, 32'h0, 1'b0, none);
        add_row(ktr_pkg::CMD_CLEAR,  16'h5A5A, 32'hDEAD_BEEF, 1'b1,
                result_of(ktr_pkg::ST_CLEARED, 0, 16'h0000, 32'h0, 0, 1'b1));
        add_row(ktr_pkg::CMD_LIST,   16'h0000, 32'h0, 1'b1,
                result_of(ktr_pkg::ST_LISTEMPTY, 0, 16'h0000, 32'h0, 0, 1'b1));
        add_row(ktr_pkg::CMD_UPSERT, 16'hABCD, 32'hFFFF_FFFF, 1'b1,
                result_of(ktr_pkg::ST_ADDED, 0, 16'hABCD, 32'hFFFF_FFFF, 1, 1'b1));
        add_row(ktr_pkg::CMD_FIND,   16'hABCD, 32'h0, 1'b1,
                result_of(ktr_pkg::ST_FOUND, 0, 16'hABCD, 32'hFFFF_FFFF, 1, 1'b1));
    endtask

    // Mostly upserts on a small id pool so the table fills, evicts and drops;
    // scores mix narrow ties, extremes and full-range values.
    task automatic draw_request(output logic [ktr_pkg::CMD_W-1:0] cmd,
                                output logic [ktr_pkg::ID_W-1:0] id,
                                output logic [ktr_pkg::SCORE_W-1:0] sc);
        int roll;
        int step;
        roll = $urandom_range(0, 99);
        if (roll < 46)
            cmd = ktr_pkg::CMD_UPSERT;
        else if (roll < 58)
            cmd = ktr_pkg::CMD_REMOVE;
        else if (roll < 72)
            cmd = ktr_pkg::CMD_FIND;
        else if (roll < 88)
            cmd = ktr_pkg::CMD_LIST;
        else if (roll < 92)
            cmd = ktr_pkg::CMD_CLEAR;
        else
            case ($urandom_range(0, 2))
                0:       cmd = CMD_RSVD5;
                1:       cmd = CMD_RSVD6;
                default: cmd = CMD_RSVD7;
            endcase

        if ($urandom_range(0, 9) < 8)
            id = ktr_pkg::ID_W'($urandom_range(0, ID_POOL - 1));
        else
            id = ktr_pkg::ID_W'($urandom);

        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            step = $urandom_range(0, 16);
            sc   = ktr_pkg::SCORE_W'((step - 8) * 256);
        end
        else if (roll < 60)
            case ($urandom_range(0, 4))
                0:       sc = 32'h7FFF_FFFF;
                1:       sc = 32'h8000_0000;
                2:       sc = 32'h0000_0000;
                3:       sc = 32'hFFFF_FFFF;
                default: sc = 32'h0000_0001;
            endcase
        else
            sc = $urandom;
    endtask

    // n counts only requests the block acts on
    task automatic run_random(input int n, input logic gapless);
        int                          done_cnt;
        logic [ktr_pkg::CMD_W-1:0]   cmd;
        logic [ktr_pkg::ID_W-1:0]    id;
        logic [ktr_pkg::SCORE_W-1:0] sc;
        ktr_pkg::result_t            none;
        done_cnt = 0;
        none     = '0;
        while (done_cnt < n)
        begin
            draw_request(cmd, id, sc);
            if (!gapless && !quiet_tail && $urandom_range(0, 3) == 0)
                sender_idle($urandom_range(1, 17));
            send_request(cmd, id, sc, 1'b0, none);
            if (cmd <= ktr_pkg::CMD_LIST)
                done_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    task automatic check_ranking_result();
        ktr_pkg::result_t want;
        ktr_pkg::result_t seen;
        seen.status      = m_tdata[3:0];
        seen.position    = m_tdata[6:4];
        seen.entry_id    = m_tdata[22:7];
        seen.entry_score = m_tdata[54:23];
        seen.count       = m_tdata[57:55];
        seen.last        = m_tlast;
        n_results++;
        if (ranking_results_due.size() == 0)
        begin
            $display("%0t ns: result with nothing pending, expected none, actual status %0d id %h",
                     $time, seen.status, seen.entry_id);
            mismatches++;
        end
        else
        begin
            want = ranking_results_due.pop_front();
            compare_field("status",      want.status,      seen.status);
            compare_field("position",    want.position,    seen.position);
            compare_field("entry_id",    want.entry_id,    seen.entry_id);
            compare_field("entry_score", want.entry_score, seen.entry_score);
            compare_field("count",       want.count,       seen.count);
            compare_field("last",        want.last,        seen.last);
        end
    endtask

    // outputs sampled at the rising edge, before the block updates them
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_ranking_result();
    end

    // Receiver: random ready/stall bursts, one long stall on
    // request from the sender, steady ready in the quiet tail.
    initial
    begin
        m_tready    = 1'b0;
        hold_active = 1'b0;
        forever
        begin
            if (long_hold_req)
            begin
                @(negedge clk) m_tready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_active = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                @(negedge clk) m_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
            else
            begin
                @(negedge clk) m_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int w;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        long_hold_req = 1'b0;
        quiet_tail    = 1'b0;
        shadow_count  = 0;
        mismatches    = 0;
        n_requests    = 0;
        n_ignored     = 0;
        n_results     = 0;
        n_list_runs   = 0;
        n_evict       = 0;
        n_raised      = 0;
        n_dropped     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed table, with random gaps on the request side
        build_directed();
        foreach (directed_rows[k])
        begin
            if ($urandom_range(0, 3) == 0)
                sender_idle($urandom_range(1, 17));
            send_request(directed_rows[k].cmd, directed_rows[k].id, directed_rows[k].score,
                         directed_rows[k].typed, directed_rows[k].want);
        end
        drain_results();

        run_random(110, 1'b0);

        // long output stall while requests keep coming: the block backs up
        // and has to hold s_tready low
        long_hold_req = 1'b1;
        sender_idle(1);
        while (!hold_active)
            @(negedge clk);
        long_hold_req = 1'b0;
        run_random(HOLD_BURST, 1'b1);
        drain_results();

        run_random(100, 1'b0);
        drain_results();

        // tail at full rate, no idling anywhere
        quiet_tail = 1'b1;
        run_random(50, 1'b1);
        sender_idle(1);

        for (w = 0; w < END_WAIT && ranking_results_due.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (ranking_results_due.size() != 0)
        begin
            $display("%0t ns: %0d results never arrived", $time, ranking_results_due.size());
            mismatches++;
        end

        $display("run: %0d requests (%0d with unknown codes), %0d results checked",
                 n_requests, n_ignored, n_results);
        $display("run: %0d list runs, %0d evictions, %0d raises, %0d dropped, one long stall",
                 n_list_runs, n_evict, n_raised, n_dropped);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
